/* rtl/core/psve_pkg.sv */
// ----------------------------------------------------------------------------
// psve_pkg
// Shared constants and types of the packed signed varint encoder.
// ----------------------------------------------------------------------------
package psve_pkg;

  // Width of the encoded integer; the input field stays 64 bits wide.
  localparam int VALUE_WIDTH = 64;
  localparam int IN_W        = 64;

  // Data bits in the first byte and in each later byte.
  localparam int FIRST_DATA_W = 6;
  localparam int NEXT_DATA_W  = 7;

  // Bits left after the first byte has been taken off.
  localparam int REM_W = VALUE_WIDTH - FIRST_DATA_W;

  // Entries of the queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Classified value on its way from front to back.
  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } psve_entry_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } psve_qstat_t;

endpackage

/* rtl/core/psve_if.sv */
// ----------------------------------------------------------------------------
// psve_if
// Valid/ready channels of the encoder: signed value in, encoded byte out.
// ----------------------------------------------------------------------------
interface psve_in_if
  import psve_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface psve_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* rtl/core/psve_front.sv */
// ----------------------------------------------------------------------------
// psve_front
// Accepts values, folds negatives to their complement and pushes the queue.
// ----------------------------------------------------------------------------
module psve_front
  import psve_pkg::*;
(
  psve_in_if.sink     item,
  input  psve_qstat_t qstat,
  output logic        push,
  output psve_entry_t entry
);

  logic [VALUE_WIDTH-1:0] v;

  // Take the low bits; the top one is the sign.
  assign v          = item.value[VALUE_WIDTH-1:0];
  assign entry.neg  = v[VALUE_WIDTH-1];
  assign entry.mag  = entry.neg ? ~v : v;

  // Transfer whenever the queue has room.
  assign item.ready = !qstat.full;
  assign push       = item.valid && !qstat.full;

endmodule

/* rtl/core/psve_queue.sv */
// ----------------------------------------------------------------------------
// psve_queue
// Small flip-flop FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module psve_queue
  import psve_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  psve_entry_t wr_entry,
  input  logic        pop,
  output psve_entry_t rd_entry,
  output psve_qstat_t qstat
);

  psve_entry_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign rd_entry    = mem[rd_ptr];

  // Store pushed entries.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!qstat.full || pop))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/core/psve_back.sv */
// ----------------------------------------------------------------------------
// psve_back
// Emits the bytes of one queued value, one per cycle while result is ready, from a shift register.
// ----------------------------------------------------------------------------
module psve_back
  import psve_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  psve_qstat_t qstat,
  input  psve_entry_t entry,
  output logic        pop,
  psve_out_if.source  result
);

  logic             res_valid;
  logic [7:0]       res_byte;
  logic             res_last;
  logic [REM_W-1:0] rem;

  logic             done;
  logic             step;
  logic [REM_W-1:0] first_rem;
  logic             first_more;
  logic             next_more;

  // Output register is free when empty or its last byte leaves now.
  assign done  = !res_valid || (result.ready && res_last);
  assign step  = res_valid && result.ready && !res_last;
  assign pop   = done && !qstat.empty;

  assign first_rem  = entry.mag[VALUE_WIDTH-1:FIRST_DATA_W];
  assign first_more = (first_rem != '0);
  assign next_more  = ((rem >> NEXT_DATA_W) != '0);

  // Hold the valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= !qstat.empty;
    end
  end

  // Load the first byte or shift out the next seven bits.
  always_ff @(posedge clk) begin
    if (pop) begin
      res_byte <= {first_more, entry.neg, entry.mag[FIRST_DATA_W-1:0]};
      res_last <= !first_more;
      rem      <= first_rem;
    end else if (step) begin
      res_byte <= {next_more, NEXT_DATA_W'(rem)};
      res_last <= !next_more;
      rem      <= rem >> NEXT_DATA_W;
    end
  end

  assign result.valid    = res_valid;
  assign result.out_byte = res_byte;
  assign result.last     = res_last;

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_last) |-> (rem == '0))
    else $error("last byte with data left");
  a_more_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_byte[7] == !res_last))
    else $error("continuation flag disagrees with last");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result.ready && res_last && qstat.empty) |=> !res_valid)
    else $error("output stays valid after final transfer");

endmodule

/* rtl/core/packed_signed_varint_encoder.sv */
// ----------------------------------------------------------------------------
// packed_signed_varint_encoder
// Encodes one signed value into 1 to 10 packed varint bytes.
// ----------------------------------------------------------------------------
// Each value accepted on item produces its bytes on result, one transfer per
// byte, with last set on the final one. The first byte carries the sign in
// bit 6 and the low six data bits; later bytes carry seven bits each; bit 7
// marks that another byte follows. A value takes 1 + ceil(b / 7) bytes on
// the result side, where b is the bit length of its magnitude above the low
// six bits: 1 byte for small values, 10 for the widest. The bytes come from
// the back end's shift register, one byte per cycle while result is ready. A
// two-entry queue lets item keep accepting values while result is stalled.
module packed_signed_varint_encoder
  import psve_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  psve_in_if.sink    item,
  psve_out_if.source result
);

  psve_entry_t push_entry;
  psve_entry_t pop_entry;
  psve_qstat_t qstat;
  logic        push;
  logic        pop;

  // Classify incoming values.
  psve_front u_front (
    .item  (item),
    .qstat (qstat),
    .push  (push),
    .entry (push_entry)
  );

  // Decouple front and back.
  psve_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (pop_entry),
    .qstat    (qstat)
  );

  // Emit the bytes.
  psve_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .entry  (pop_entry),
    .pop    (pop),
    .result (result)
  );

endmodule
